@@ design/assert_macros.svh @@
// assertion macros shared by the top and divider design files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CVT_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
`define CVT_ASSERT_NEXT(label, clk, rst_n, cond, res) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (res)) \
        else $error("assertion failed");
`else
`define CVT_ASSERT(label, clk, rst_n, prop)
`define CVT_ASSERT_NEXT(label, clk, rst_n, cond, res)
`endif
`endif

@@ design/cvt_pkg.sv @@
`timescale 1ns / 1ps
package cvt_pkg;
    localparam int POS_W = 32;
    localparam int TRIG_W = 16;
    localparam int T_W = POS_W + 1;
    localparam int P1_W = T_W + TRIG_W;
    localparam int S1_W = P1_W + 1;
    localparam int R1_W = S1_W - 14;
    localparam int P2_W = R1_W + TRIG_W + 1;
    localparam int R2_W = P2_W - 14;
    localparam int DEPTH_W = 31;
    localparam int COLOR_W = 32;
    localparam int MAG_W = R2_W;
    localparam int FOV_W = 10;
    localparam int M600_W = MAG_W + FOV_W;
    localparam int NUM_W = M600_W + 16 + 1;
    localparam int QB = 34;
    localparam int REM_W = DEPTH_W;
    localparam int SUM_W = QB + 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [DEPTH_W-1:0] NEAR_DEPTH = 31'd6554;
    localparam logic [FOV_W-1:0] FOV_SCALE = 10'd600;
    localparam int SCREEN_WIDTH_DEF = 640;
    localparam int SCREEN_HEIGHT_DEF = 480;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CAMERA_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAMERA_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CAMERA_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_YAW_COS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_YAW_SIN = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PITCH_COS = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_PITCH_SIN = 3'd6;

    typedef struct packed {
        logic signed [TRIG_W-1:0] yaw_cos;
        logic signed [TRIG_W-1:0] yaw_sin;
        logic signed [TRIG_W-1:0] pitch_cos;
        logic signed [TRIG_W-1:0] pitch_sin;
    } trig_t;

    typedef struct packed {
        logic signed [R1_W-1:0] x1;
        logic signed [R2_W-1:0] y2;
        logic signed [R2_W-1:0] z2;
        logic [COLOR_W-1:0] color;
    } rot_t;

    typedef struct packed {
        logic [QB-1:0] q;
        logic ovf;
        logic neg;
    } quot_t;
endpackage

@@ design/camera_vertex_transform.sv @@
`timescale 1ns / 1ps
// Camera vertex transform: subtracts the camera position, rotates by yaw then
// pitch from the sine/cosine registers, clamps depth to at least 0.1 and
// projects x and y to screen pixels (scale 600, centered, y flipped), with
// saturation. One vertex is accepted every clock while no result waits; a vertex
// passes the 5-stage rotation, 3 stages of depth clamp and numerator setup,
// the 35-stage restoring divider (an overflow check stage, then one quotient
// bit per stage) and the output register. A stalled output holds the whole
// pipeline. Configuration writes are meant for idle.
`include "assert_macros.svh"
module camera_vertex_transform #(
    parameter int SCREEN_WIDTH = cvt_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = cvt_pkg::SCREEN_HEIGHT_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_we,
    input  logic [cvt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [cvt_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic in_valid,
    output logic in_ready,
    input  logic signed [cvt_pkg::POS_W-1:0] world_x,
    input  logic signed [cvt_pkg::POS_W-1:0] world_y,
    input  logic signed [cvt_pkg::POS_W-1:0] world_z,
    input  logic [cvt_pkg::COLOR_W-1:0] vertex_color,
    output logic out_valid,
    input  logic out_ready,
    output logic signed [cvt_pkg::POS_W-1:0] screen_x,
    output logic signed [cvt_pkg::POS_W-1:0] screen_y,
    output logic [cvt_pkg::DEPTH_W-1:0] depth,
    output logic [cvt_pkg::COLOR_W-1:0] color_out
);
    import cvt_pkg::*;

    localparam logic signed [SUM_W-1:0] CX = SUM_W'((SCREEN_WIDTH / 2) * 65536);
    localparam logic signed [SUM_W-1:0] CY = SUM_W'((SCREEN_HEIGHT / 2) * 65536);
    localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'(64'sd2147483647);
    localparam logic signed [SUM_W-1:0] SAT_MIN = -SUM_W'(64'sd2147483648);
    localparam logic signed [R2_W-1:0] NEAR_S = R2_W'(NEAR_DEPTH);
    localparam logic signed [R2_W-1:0] FAR_S = R2_W'(64'sd2147483647);

    logic signed [POS_W-1:0] cam_x_reg, cam_y_reg, cam_z_reg;
    trig_t trig_reg;
    logic adv;
    logic rot_valid;
    rot_t rot;
    logic [2:0] v_reg;
    logic [DEPTH_W-1:0] d1_reg, d2_reg, d3_reg;
    logic [MAG_W-1:0] mx_reg, my_reg;
    logic [M600_W-1:0] mx6_reg, my6_reg;
    logic [NUM_W-1:0] nx_reg, ny_reg;
    logic [1:0] neg1_reg, neg2_reg, neg3_reg;
    logic [COLOR_W-1:0] c1_reg, c2_reg, c3_reg;
    logic signed [MAG_W-1:0] x1_ext;
    logic div_valid;
    quot_t qx, qy;
    logic [DEPTH_W-1:0] div_depth;
    logic [COLOR_W-1:0] div_color;
    logic signed [SUM_W-1:0] vx, vy, sum_x, sum_y;
    logic signed [POS_W-1:0] sx_next, sy_next;
    logic out_valid_reg;
    logic signed [POS_W-1:0] sx_reg, sy_reg;
    logic [DEPTH_W-1:0] depth_reg;
    logic [COLOR_W-1:0] color_reg;

    // whole pipeline moves unless a result waits
    assign adv = !out_valid_reg || out_ready;
    assign in_ready = adv;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cam_x_reg <= '0;
            cam_y_reg <= '0;
            cam_z_reg <= '0;
            trig_reg.yaw_cos <= 16'sd16384;
            trig_reg.yaw_sin <= '0;
            trig_reg.pitch_cos <= 16'sd16384;
            trig_reg.pitch_sin <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_CAMERA_X: cam_x_reg <= cfg_data;
                CFG_CAMERA_Y: cam_y_reg <= cfg_data;
                CFG_CAMERA_Z: cam_z_reg <= cfg_data;
                CFG_YAW_COS: trig_reg.yaw_cos <= cfg_data[TRIG_W-1:0];
                CFG_YAW_SIN: trig_reg.yaw_sin <= cfg_data[TRIG_W-1:0];
                CFG_PITCH_COS: trig_reg.pitch_cos <= cfg_data[TRIG_W-1:0];
                CFG_PITCH_SIN: trig_reg.pitch_sin <= cfg_data[TRIG_W-1:0];
                default: ;
            endcase
        end
    end

    cvt_rotate u_rotate (
        .clk(clk),
        .rst_n(rst_n),
        .adv(adv),
        .in_valid(in_valid),
        .world_x(world_x),
        .world_y(world_y),
        .world_z(world_z),
        .vertex_color(vertex_color),
        .cam_x(cam_x_reg),
        .cam_y(cam_y_reg),
        .cam_z(cam_z_reg),
        .trig(trig_reg),
        .out_valid(rot_valid),
        .rot(rot)
    );

    assign x1_ext = MAG_W'(rot.x1);

    // valid bits of clamp and numerator stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[1:0], rot_valid};
        end
    end

    // depth clamp, magnitudes, scale by 600, add half divisor
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (rot.z2 < NEAR_S)
            begin
                d1_reg <= NEAR_DEPTH;
            end
            else if (rot.z2 > FAR_S)
            begin
                d1_reg <= '1;
            end
            else
            begin
                d1_reg <= rot.z2[DEPTH_W-1:0];
            end
            mx_reg <= x1_ext[MAG_W-1] ? MAG_W'(-x1_ext) : MAG_W'(x1_ext);
            my_reg <= rot.y2[R2_W-1] ? MAG_W'(-rot.y2) : MAG_W'(rot.y2);
            neg1_reg <= {rot.y2[R2_W-1], x1_ext[MAG_W-1]};
            c1_reg <= rot.color;

            mx6_reg <= M600_W'(mx_reg) * M600_W'(FOV_SCALE);
            my6_reg <= M600_W'(my_reg) * M600_W'(FOV_SCALE);
            d2_reg <= d1_reg;
            neg2_reg <= neg1_reg;
            c2_reg <= c1_reg;

            nx_reg <= NUM_W'({mx6_reg, 16'h0000}) + NUM_W'(d2_reg >> 1);
            ny_reg <= NUM_W'({my6_reg, 16'h0000}) + NUM_W'(d2_reg >> 1);
            d3_reg <= d2_reg;
            neg3_reg <= neg2_reg;
            c3_reg <= c2_reg;
        end
    end

    cvt_divider u_divider (
        .clk(clk),
        .rst_n(rst_n),
        .adv(adv),
        .in_valid(v_reg[2]),
        .num_x(nx_reg),
        .num_y(ny_reg),
        .neg_x(neg3_reg[0]),
        .neg_y(neg3_reg[1]),
        .divisor(d3_reg),
        .color_in(c3_reg),
        .out_valid(div_valid),
        .quot_x(qx),
        .quot_y(qy),
        .depth_q(div_depth),
        .color_q(div_color)
    );

    // sign, screen offset and saturation
    always_comb
    begin
        vx = qx.neg ? -SUM_W'(qx.q) : SUM_W'(qx.q);
        vy = qy.neg ? -SUM_W'(qy.q) : SUM_W'(qy.q);
        sum_x = vx + CX;
        sum_y = CY - vy;
        if (qx.ovf)
        begin
            sx_next = qx.neg ? SAT_MIN[POS_W-1:0] : SAT_MAX[POS_W-1:0];
        end
        else if (sum_x > SAT_MAX)
        begin
            sx_next = SAT_MAX[POS_W-1:0];
        end
        else if (sum_x < SAT_MIN)
        begin
            sx_next = SAT_MIN[POS_W-1:0];
        end
        else
        begin
            sx_next = sum_x[POS_W-1:0];
        end
        if (qy.ovf)
        begin
            sy_next = qy.neg ? SAT_MAX[POS_W-1:0] : SAT_MIN[POS_W-1:0];
        end
        else if (sum_y > SAT_MAX)
        begin
            sy_next = SAT_MAX[POS_W-1:0];
        end
        else if (sum_y < SAT_MIN)
        begin
            sy_next = SAT_MIN[POS_W-1:0];
        end
        else
        begin
            sy_next = sum_y[POS_W-1:0];
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= div_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sx_reg <= sx_next;
            sy_reg <= sy_next;
            depth_reg <= div_depth;
            color_reg <= div_color;
        end
    end

    assign out_valid = out_valid_reg;
    assign screen_x = sx_reg;
    assign screen_y = sy_reg;
    assign depth = depth_reg;
    assign color_out = color_reg;

    // depth never below the near plane, stall only from a waiting result
    `CVT_ASSERT(a_depth_near, clk, rst_n, !out_valid_reg || (depth_reg >= NEAR_DEPTH))
    `CVT_ASSERT(a_stall_cause, clk, rst_n, in_ready || (out_valid_reg && !out_ready))
    `CVT_ASSERT_NEXT(a_hold_out, clk, rst_n, out_valid_reg && !out_ready, out_valid_reg && $stable(color_reg))
endmodule

@@ design/cvt_rotate.sv @@
`timescale 1ns / 1ps
module cvt_rotate (
    input  logic clk,
    input  logic rst_n,
    input  logic adv,
    input  logic in_valid,
    input  logic signed [cvt_pkg::POS_W-1:0] world_x,
    input  logic signed [cvt_pkg::POS_W-1:0] world_y,
    input  logic signed [cvt_pkg::POS_W-1:0] world_z,
    input  logic [cvt_pkg::COLOR_W-1:0] vertex_color,
    input  logic signed [cvt_pkg::POS_W-1:0] cam_x,
    input  logic signed [cvt_pkg::POS_W-1:0] cam_y,
    input  logic signed [cvt_pkg::POS_W-1:0] cam_z,
    input  cvt_pkg::trig_t trig,
    output logic out_valid,
    output cvt_pkg::rot_t rot
);
    import cvt_pkg::*;

    localparam logic signed [S1_W-1:0] RND1 = S1_W'(1 << 13);
    localparam logic signed [P2_W-1:0] RND2 = P2_W'(1 << 13);

    logic [4:0] v_reg;
    logic signed [T_W-1:0] tx_reg, ty_reg, tz_reg, ty2_reg, ty3_reg;
    logic signed [P1_W-1:0] pxc_reg, pzs_reg, pxs_reg, pzc_reg;
    logic signed [R1_W-1:0] x1_reg, z1_reg, x1d_reg, x1e_reg;
    logic signed [P2_W-1:0] qyc_reg, qzs_reg, qys_reg, qzc_reg;
    logic signed [R2_W-1:0] y2_reg, z2_reg;
    logic [COLOR_W-1:0] col_reg [0:4];
    logic signed [S1_W-1:0] sx1, sz1;
    logic signed [P2_W-1:0] sy2, sz2;

    // rounding of the rotation sums, ties toward +infinity
    always_comb
    begin
        sx1 = S1_W'(pxc_reg) - S1_W'(pzs_reg) + RND1;
        sz1 = S1_W'(pxs_reg) + S1_W'(pzc_reg) + RND1;
        sy2 = qyc_reg - qzs_reg + RND2;
        sz2 = qys_reg + qzc_reg + RND2;
    end

    // stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[3:0], in_valid};
        end
    end

    // translate, yaw products, yaw sums, pitch products, pitch sums
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tx_reg <= T_W'(world_x) - T_W'(cam_x);
            ty_reg <= T_W'(world_y) - T_W'(cam_y);
            tz_reg <= T_W'(world_z) - T_W'(cam_z);
            col_reg[0] <= vertex_color;

            pxc_reg <= tx_reg * trig.yaw_cos;
            pzs_reg <= tz_reg * trig.yaw_sin;
            pxs_reg <= tx_reg * trig.yaw_sin;
            pzc_reg <= tz_reg * trig.yaw_cos;
            ty2_reg <= ty_reg;
            col_reg[1] <= col_reg[0];

            x1_reg <= sx1[S1_W-1:14];
            z1_reg <= sz1[S1_W-1:14];
            ty3_reg <= ty2_reg;
            col_reg[2] <= col_reg[1];

            qyc_reg <= ty3_reg * trig.pitch_cos;
            qzs_reg <= z1_reg * trig.pitch_sin;
            qys_reg <= ty3_reg * trig.pitch_sin;
            qzc_reg <= z1_reg * trig.pitch_cos;
            x1d_reg <= x1_reg;
            col_reg[3] <= col_reg[2];

            y2_reg <= sy2[P2_W-1:14];
            z2_reg <= sz2[P2_W-1:14];
            x1e_reg <= x1d_reg;
            col_reg[4] <= col_reg[3];
        end
    end

    assign out_valid = v_reg[4];
    assign rot.x1 = x1e_reg;
    assign rot.y2 = y2_reg;
    assign rot.z2 = z2_reg;
    assign rot.color = col_reg[4];
endmodule

@@ design/cvt_divider.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"
module cvt_divider (
    input  logic clk,
    input  logic rst_n,
    input  logic adv,
    input  logic in_valid,
    input  logic [cvt_pkg::NUM_W-1:0] num_x,
    input  logic [cvt_pkg::NUM_W-1:0] num_y,
    input  logic neg_x,
    input  logic neg_y,
    input  logic [cvt_pkg::DEPTH_W-1:0] divisor,
    input  logic [cvt_pkg::COLOR_W-1:0] color_in,
    output logic out_valid,
    output cvt_pkg::quot_t quot_x,
    output cvt_pkg::quot_t quot_y,
    output logic [cvt_pkg::DEPTH_W-1:0] depth_q,
    output logic [cvt_pkg::COLOR_W-1:0] color_q
);
    import cvt_pkg::*;

    localparam int HI_W = NUM_W - QB;

    logic v_reg [0:QB];
    logic [REM_W-1:0] r_reg [0:QB][0:1];
    logic [QB-1:0] n_reg [0:QB][0:1];
    logic [QB-1:0] q_reg [0:QB][0:1];
    logic ovf_reg [0:QB][0:1];
    logic neg_reg [0:QB][0:1];
    logic [DEPTH_W-1:0] d_reg [0:QB];
    logic [COLOR_W-1:0] col_reg [0:QB];
    logic [NUM_W-1:0] num_in [0:1];
    logic neg_in [0:1];

    assign num_in[0] = num_x;
    assign num_in[1] = num_y;
    assign neg_in[0] = neg_x;
    assign neg_in[1] = neg_y;

    // valid bits along the divider
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= QB; k++)
            begin
                v_reg[k] <= 1'b0;
            end
        end
        else if (adv)
        begin
            v_reg[0] <= in_valid;
            for (int k = 1; k <= QB; k++)
            begin
                v_reg[k] <= v_reg[k-1];
            end
        end
    end

    // divisor and color travel with the quotient
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_reg[0] <= divisor;
            col_reg[0] <= color_in;
            for (int k = 1; k <= QB; k++)
            begin
                d_reg[k] <= d_reg[k-1];
                col_reg[k] <= col_reg[k-1];
            end
        end
    end

    genvar l, j;
    generate
        for (l = 0; l < 2; l++)
        begin : g_lane
            logic [HI_W-1:0] hi;
            assign hi = num_in[l][NUM_W-1:QB];

            // overflow check and first partial remainder
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    ovf_reg[0][l] <= hi >= HI_W'(divisor);
                    r_reg[0][l] <= hi[REM_W-1:0];
                    n_reg[0][l] <= num_in[l][QB-1:0];
                    q_reg[0][l] <= '0;
                    neg_reg[0][l] <= neg_in[l];
                end
            end

            for (j = 1; j <= QB; j++)
            begin : g_step
                logic [REM_W:0] t;
                logic ge;
                logic [REM_W:0] diff;

                // one quotient bit per stage
                always_comb
                begin
                    t = {r_reg[j-1][l], n_reg[j-1][l][QB-j]};
                    ge = t >= {1'b0, d_reg[j-1]};
                    diff = t - {1'b0, d_reg[j-1]};
                end

                always_ff @(posedge clk)
                begin
                    if (adv)
                    begin
                        r_reg[j][l] <= ge ? diff[REM_W-1:0] : t[REM_W-1:0];
                        n_reg[j][l] <= n_reg[j-1][l];
                        q_reg[j][l] <= {q_reg[j-1][l][QB-2:0], ge};
                        ovf_reg[j][l] <= ovf_reg[j-1][l];
                        neg_reg[j][l] <= neg_reg[j-1][l];
                    end
                end
            end
        end
    endgenerate

    assign out_valid = v_reg[QB];
    assign quot_x.q = q_reg[QB][0];
    assign quot_x.ovf = ovf_reg[QB][0];
    assign quot_x.neg = neg_reg[QB][0];
    assign quot_y.q = q_reg[QB][1];
    assign quot_y.ovf = ovf_reg[QB][1];
    assign quot_y.neg = neg_reg[QB][1];
    assign depth_q = d_reg[QB];
    assign color_q = col_reg[QB];

    // final remainders stay below the divisor
    `CVT_ASSERT(a_rem_x, clk, rst_n, !(v_reg[QB] && !ovf_reg[QB][0]) || (r_reg[QB][0] < d_reg[QB]))
    `CVT_ASSERT(a_rem_y, clk, rst_n, !(v_reg[QB] && !ovf_reg[QB][1]) || (r_reg[QB][1] < d_reg[QB]))
endmodule

@@ sim/camera_vertex_transform_tb.sv @@
`timescale 1ns / 1ps
module camera_vertex_transform_tb;
    import cvt_pkg::*;

    typedef struct packed {
        logic [POS_W-1:0] sx;
        logic [POS_W-1:0] sy;
        logic [DEPTH_W-1:0] dep;
        logic [COLOR_W-1:0] col;
    } projected_t;

    typedef struct {
        logic [POS_W-1:0] wx;
        logic [POS_W-1:0] wy;
        logic [POS_W-1:0] wz;
        logic [COLOR_W-1:0] col;
        bit typed;
        logic [POS_W-1:0] esx;
        logic [POS_W-1:0] esy;
        logic [DEPTH_W-1:0] edep;
    } vertex_row_t;

    localparam int PHASES = 6;
    localparam int ITEMS_PER_PHASE = 75;
    localparam int SETTLE_CYCLES = 60;
    localparam logic [POS_W-1:0] CENTER_X = 32'd20971520;
    localparam logic [POS_W-1:0] CENTER_Y = 32'd15728640;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [POS_W-1:0] world_x = '0;
    logic signed [POS_W-1:0] world_y = '0;
    logic signed [POS_W-1:0] world_z = '0;
    logic [COLOR_W-1:0] vertex_color = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [POS_W-1:0] screen_x;
    logic signed [POS_W-1:0] screen_y;
    logic [DEPTH_W-1:0] depth;
    logic [COLOR_W-1:0] color_out;

    // shadow copy of the camera registers
    logic signed [POS_W-1:0] cam_x = '0, cam_y = '0, cam_z = '0;
    logic signed [TRIG_W-1:0] yaw_c = 16'sd16384, yaw_s = '0;
    logic signed [TRIG_W-1:0] pitch_c = 16'sd16384, pitch_s = '0;

    projected_t projected_q[$];
    int errors = 0;
    int sent = 0;
    int received = 0;
    int send_idle = 0;
    int recv_idle = 0;
    int hold_cycles = 0;

    camera_vertex_transform uut (.*);

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run limit
    initial
    begin
        #20ms;
        $display("Test completed with failures");
        $finish;
    end

    // magnitude division, ties away from zero
    function automatic logic signed [127:0] div_nearest(logic signed [127:0] n,
                                                        logic signed [127:0] d);
        logic signed [127:0] m;
        logic signed [127:0] q;
        m = (n < 0) ? -n : n;
        q = (m + d / 2) / d;
        return (n < 0) ? -q : q;
    endfunction

    function automatic logic [POS_W-1:0] sat_pos(logic signed [127:0] v);
        if (v > 128'sd2147483647)
            return 32'h7fffffff;
        if (v < -128'sd2147483648)
            return 32'h80000000;
        return v[POS_W-1:0];
    endfunction

    // translate, rotate by yaw and pitch, clamp depth, project
    function automatic projected_t project_vertex(logic signed [POS_W-1:0] wx,
                                                  logic signed [POS_W-1:0] wy,
                                                  logic signed [POS_W-1:0] wz,
                                                  logic [COLOR_W-1:0] col);
        logic signed [127:0] tx, ty, tz, x1, z1, y2, z2, d;
        projected_t r;
        tx = 128'(wx) - 128'(cam_x);
        ty = 128'(wy) - 128'(cam_y);
        tz = 128'(wz) - 128'(cam_z);
        x1 = (tx * yaw_c - tz * yaw_s + 8192) >>> 14;
        z1 = (tx * yaw_s + tz * yaw_c + 8192) >>> 14;
        y2 = (ty * pitch_c - z1 * pitch_s + 8192) >>> 14;
        z2 = (ty * pitch_s + z1 * pitch_c + 8192) >>> 14;
        d = z2;
        if (d < 6554)
            d = 6554;
        if (d > 128'sd2147483647)
            d = 128'sd2147483647;
        r.sx = sat_pos(div_nearest(x1 * 600 * 65536, d) + 128'sd20971520);
        r.sy = sat_pos(128'sd15728640 - div_nearest(y2 * 600 * 65536, d));
        r.dep = d[DEPTH_W-1:0];
        r.col = col;
        return r;
    endfunction

    // register writes, one per cycle, block idle
    task automatic write_camera(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                                logic [15:0] yc, logic [15:0] ys,
                                logic [15:0] pc, logic [15:0] ps);
        logic [31:0] vals[8];
        logic [CFG_IDX_W-1:0] idx[8];
        vals = '{cx, cy, cz, {16'h0, yc}, {16'h0, ys}, {16'h0, pc}, {16'h0, ps},
                 $urandom};
        idx = '{CFG_CAMERA_X, CFG_CAMERA_Y, CFG_CAMERA_Z, CFG_YAW_COS, CFG_YAW_SIN,
                CFG_PITCH_COS, CFG_PITCH_SIN, CFG_UNUSED};
        for (int i = 0; i < 8; i++)
        begin
            @(negedge clk);
            cfg_we <= 1'b1;
            cfg_index <= idx[i];
            cfg_data <= vals[i];
        end
        @(negedge clk);
        cfg_we <= 1'b0;
        cam_x = cx;
        cam_y = cy;
        cam_z = cz;
        yaw_c = yc;
        yaw_s = ys;
        pitch_c = pc;
        pitch_s = ps;
    endtask

    // one input transaction; valid stays up when the next one follows at once
    task automatic send_vertex(logic [31:0] wx, logic [31:0] wy, logic [31:0] wz,
                               logic [31:0] col, bit typed, projected_t typed_exp);
        @(negedge clk);
        if ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            do
                @(negedge clk);
            while ($urandom_range(99) < send_idle);
        end
        in_valid <= 1'b1;
        world_x <= wx;
        world_y <= wy;
        world_z <= wz;
        vertex_color <= col;
        do
            @(posedge clk);
        while (!in_ready);
        projected_q.push_back(typed ? typed_exp : project_vertex(wx, wy, wz, col));
        sent++;
    endtask

    task automatic drain;
        @(negedge clk);
        in_valid <= 1'b0;
        wait (projected_q.size() == 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // receiver readiness, with an optional long hold-off
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            out_ready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_idle);
    end

    // output check against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            received++;
            if (projected_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result x=%h y=%h d=%h c=%h", $time,
                         screen_x, screen_y, depth, color_out);
            end
            else
            begin
                projected_t e;
                e = projected_q.pop_front();
                if (screen_x !== e.sx)
                begin
                    errors++;
                    $display("%0t: screen_x expected %h actual %h", $time, e.sx, screen_x);
                end
                if (screen_y !== e.sy)
                begin
                    errors++;
                    $display("%0t: screen_y expected %h actual %h", $time, e.sy, screen_y);
                end
                if (depth !== e.dep)
                begin
                    errors++;
                    $display("%0t: depth expected %h actual %h", $time, e.dep, depth);
                end
                if (color_out !== e.col)
                begin
                    errors++;
                    $display("%0t: color_out expected %h actual %h", $time, e.col, color_out);
                end
            end
        end
    end

    // stimulus
    initial
    begin
        vertex_row_t rows[$];
        projected_t te;
        logic [31:0] wx, wy, wz;
        real ya, pa;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        // directed rows at reset settings
        rows.push_back('{0, 0, 0, 32'h0, 1, CENTER_X, CENTER_Y, 31'd6554});
        rows.push_back('{0, 0, 32'h7fffffff, 32'hffffffff, 1, CENTER_X, CENTER_Y,
                         31'h7fffffff});
        rows.push_back('{0, 0, 32'h80000000, 32'ha5a5a5a5, 1, CENTER_X, CENTER_Y,
                         31'd6554});
        rows.push_back('{32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h5a5a5a5a, 0, 0, 0, 0});
        rows.push_back('{32'h80000000, 32'h80000000, 32'h80000000, 32'h1, 0, 0, 0, 0});
        rows.push_back('{32'h7fffffff, 32'h80000000, 32'd6554, 32'h2, 0, 0, 0, 0});
        rows.push_back('{32'h80000000, 32'h7fffffff, 32'd6553, 32'h3, 0, 0, 0, 0});
        rows.push_back('{32'h00010000, 32'hffff0000, 32'd6555, 32'h4, 0, 0, 0, 0});
        rows.push_back('{32'h00008000, 32'h00008000, 32'h00010000, 32'h5, 0, 0, 0, 0});
        rows.push_back('{32'hffff8000, 32'hffff8000, 32'h00030000, 32'h6, 0, 0, 0, 0});
        rows.push_back('{32'h00640000, 32'h00c80000, 32'h000a0000, 32'h7, 0, 0, 0, 0});
        rows.push_back('{32'h7fffffff, 32'h7fffffff, 32'h00010000, 32'h8, 0, 0, 0, 0});
        foreach (rows[i])
        begin
            te = '{rows[i].esx, rows[i].esy, rows[i].edep, rows[i].col};
            send_vertex(rows[i].wx, rows[i].wy, rows[i].wz, rows[i].col, rows[i].typed, te);
        end
        drain();

        // random phases over several camera settings
        for (int ph = 0; ph < PHASES; ph++)
        begin
            send_idle = (ph < 2) ? 18 : (ph < 4) ? 51 : 0;
            recv_idle = (ph < 2) ? 51 : (ph < 4) ? 18 : 0;
            ya = $urandom_range(0, 62831) / 10000.0;
            pa = $urandom_range(0, 62831) / 10000.0;
            case (ph)
                0: write_camera(0, 0, 0, 16384, 0, 16384, 0);
                1: write_camera($urandom_range(0, 1 << 24) - (1 << 23), $urandom_range(0, 1 << 24),
                                $urandom_range(0, 1 << 24) - (1 << 23),
                                $rtoi($cos(ya) * 16384), $rtoi($sin(ya) * 16384),
                                $rtoi($cos(pa) * 16384), $rtoi($sin(pa) * 16384));
                2: write_camera(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                                16'sd16384, -16'sd16384, -16'sd16384, 16'sd16384);
                3: write_camera(32'h80000000, 32'h80000000, 32'h80000000,
                                16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
                4: write_camera($urandom, $urandom, $urandom, $urandom, $urandom,
                                $urandom, $urandom);
                default: write_camera($urandom_range(0, 1 << 26) - (1 << 25), 0,
                                      $urandom_range(0, 1 << 26) - (1 << 25),
                                      $rtoi($cos(ya) * 16384), $rtoi($sin(ya) * 16384),
                                      $rtoi($cos(pa) * 16384), $rtoi($sin(pa) * 16384));
            endcase
            // long receiver hold-off so the pipeline fills and stalls the input
            if (ph == 4)
                hold_cycles <= 300;
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if ($urandom_range(9) < 7)
                begin
                    // vertex near the camera, mostly in view
                    wx = cam_x + $urandom_range(0, 26214400) - 13107200;
                    wy = cam_y + $urandom_range(0, 26214400) - 13107200;
                    wz = cam_z + $urandom_range(6000, 32768000);
                end
                else
                begin
                    wx = $urandom;
                    wy = $urandom;
                    wz = $urandom;
                end
                send_vertex(wx, wy, wz, $urandom, 0, '0);
            end
            drain();
        end

        $display("%0d vertices sent and %0d projected over %0d camera settings,", sent,
                 received, PHASES + 1);
        $display("with sender and receiver idling and one long output stall");
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
